/* src/otd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otd_pkg
// Shared types, register indexes and helpers of the occupancy downsampler.
// ----------------------------------------------------------------------------
package otd_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int MAX_SCALE_DEF  = 16;

	localparam int DIM_W     = 13;
	localparam int SCALE_W   = 5;
	localparam int LEVEL_W   = 9;
	localparam int PIXEL_W   = 8;
	localparam int CELL_W    = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int QUO_W     = DIM_W + 1;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POOL_SCALE     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OCCUPIED_LEVEL = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FREE_LIMIT     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NEGATE_MODE    = 3'd5;

	localparam logic [LEVEL_W-1:0] OCC_LEVEL_RST  = 9'd26;
	localparam logic [LEVEL_W-1:0] FREE_LIMIT_RST = 9'd13;

	localparam logic signed [CELL_W-1:0] CELL_OCCUPIED = 8'sd100;
	localparam logic signed [CELL_W-1:0] CELL_FREE     = 8'sd0;
	localparam logic signed [CELL_W-1:0] CELL_UNKNOWN  = -8'sd1;

	typedef struct packed {
		logic occ;
		logic unk;
	} band_t;

	typedef struct packed {
		logic occ;
		logic unk;
		logic cell_done;
		logic last;
	} pix_info_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw, input int hi);
		logic [DIM_W-1:0] r;
		if (raw == '0) begin
			r = DIM_W'(1);
		end else if (32'(raw) > hi) begin
			r = DIM_W'(hi);
		end else begin
			r = raw;
		end
		return r;
	endfunction

	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] raw,
		input int hi);
		logic [SCALE_W-1:0] r;
		if (raw == '0) begin
			r = SCALE_W'(1);
		end else if (32'(raw) > hi) begin
			r = SCALE_W'(hi);
		end else begin
			r = raw;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/occupancy_threshold_downsample.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_threshold_downsample
// Grey pixel thresholding into occupancy values with square max-priority pooling.
// ----------------------------------------------------------------------------
// Takes one pixel per clock cycle unless cell_ready holds back the output; a
// cell is registered at the output once the last pixel of its block has left
// the update stage. The rate is set by the read-modify-write of the band flag
// memory (one read, one write per cycle, forwarding between back-to-back
// pixels of the same cell column). After reset and after every write to a
// known register the block clears all MAX_WIDTH entries (4096 by default) of
// the band memory, one entry per cycle; a serial divider works out the grid
// size, and no pixel is taken until both the clear and the division end.
module occupancy_threshold_downsample #(
	parameter int MAX_WIDTH  = otd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = otd_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_SCALE  = otd_pkg::MAX_SCALE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [otd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [otd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               pixel_valid,
	output logic                                    pixel_ready,
	input  wire logic [otd_pkg::PIXEL_W-1:0]        pixel,
	output logic                                    cell_valid,
	input  wire logic                               cell_ready,
	output logic signed [otd_pkg::CELL_W-1:0]       cell_value,
	output logic [otd_pkg::DIM_W-1:0]               grid_width,
	output logic [otd_pkg::DIM_W-1:0]               grid_height,
	output logic                                    last_cell
);

	localparam int CNT_W = $clog2(MAX_WIDTH);
	localparam int NW    = otd_pkg::QUO_W;

	logic [otd_pkg::DIM_W-1:0]   width_q;
	logic [otd_pkg::DIM_W-1:0]   height_q;
	logic [otd_pkg::SCALE_W-1:0] scale_q;
	logic [otd_pkg::LEVEL_W-1:0] occ_level_q;
	logic [otd_pkg::LEVEL_W-1:0] free_limit_q;
	logic                        negate_q;

	logic cfg_fire, cfg_known, restart;
	logic div_start_q, div_busy;
	logic [NW-1:0] quo_w, quo_h;

	logic             clr_busy_q;
	logic [CNT_W-1:0] clr_addr_q;

	logic                accept;
	logic [CNT_W-1:0]    scan_idx;
	otd_pkg::pix_info_t  scan_info;

	logic               v_s1;
	logic [CNT_W-1:0]   idx_s1;
	otd_pkg::pix_info_t info_s1;
	logic               byp_s1;
	otd_pkg::band_t     bypd_s1;
	logic               s1_adv, s1_fire;
	otd_pkg::band_t     rdata, old_flags, merged, wdata;

	logic               mem_we;
	logic [CNT_W-1:0]   mem_waddr;
	otd_pkg::band_t     mem_wdata;

	logic                             cell_valid_q;
	logic signed [otd_pkg::CELL_W-1:0] cell_value_q;
	logic                             last_cell_q;

	always_comb begin
		case (cfg_index)
			otd_pkg::REG_IMAGE_WIDTH, otd_pkg::REG_IMAGE_HEIGHT, otd_pkg::REG_POOL_SCALE,
			otd_pkg::REG_OCCUPIED_LEVEL, otd_pkg::REG_FREE_LIMIT,
			otd_pkg::REG_NEGATE_MODE: cfg_known = 1'b1;
			default: cfg_known = 1'b0;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign restart   = cfg_fire && cfg_known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= otd_pkg::DIM_W'(1);
			height_q     <= otd_pkg::DIM_W'(1);
			scale_q      <= otd_pkg::SCALE_W'(1);
			occ_level_q  <= otd_pkg::OCC_LEVEL_RST;
			free_limit_q <= otd_pkg::FREE_LIMIT_RST;
			negate_q     <= 1'b0;
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= restart;
			if (cfg_fire) begin
				case (cfg_index)
					otd_pkg::REG_IMAGE_WIDTH:
						width_q <= otd_pkg::clamp_dim(cfg_data, MAX_WIDTH);
					otd_pkg::REG_IMAGE_HEIGHT:
						height_q <= otd_pkg::clamp_dim(cfg_data, MAX_HEIGHT);
					otd_pkg::REG_POOL_SCALE:
						scale_q <= otd_pkg::clamp_scale(cfg_data[otd_pkg::SCALE_W-1:0],
							MAX_SCALE);
					otd_pkg::REG_OCCUPIED_LEVEL:
						occ_level_q <= cfg_data[otd_pkg::LEVEL_W-1:0];
					otd_pkg::REG_FREE_LIMIT:
						free_limit_q <= cfg_data[otd_pkg::LEVEL_W-1:0];
					otd_pkg::REG_NEGATE_MODE:
						negate_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	otd_div #(
		.NW(NW),
		.DW(otd_pkg::SCALE_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num_a (NW'(width_q) + NW'(scale_q) - NW'(1)),
		.num_b (NW'(height_q) + NW'(scale_q) - NW'(1)),
		.den   (scale_q),
		.busy  (div_busy),
		.quo_a (quo_w),
		.quo_b (quo_h)
	);

	// sweep the band memory to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (restart) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CNT_W'(1);
			if (clr_addr_q == CNT_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign s1_adv      = !cell_valid_q || cell_ready;
	assign s1_fire     = v_s1 && s1_adv;
	assign pixel_ready = !clr_busy_q && !div_busy && !div_start_q && (!v_s1 || s1_adv);
	assign accept      = pixel_valid && pixel_ready;

	otd_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_SCALE (MAX_SCALE),
		.CNT_W     (CNT_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.adv       (accept),
		.pixel     (pixel),
		.img_w     (width_q),
		.img_h     (height_q),
		.scale     (scale_q),
		.occ_level (occ_level_q),
		.free_limit(free_limit_q),
		.negate    (negate_q),
		.cell_col  (scan_idx),
		.info      (scan_info)
	);

	always_comb begin
		old_flags  = byp_s1 ? bypd_s1 : rdata;
		merged.occ = old_flags.occ | info_s1.occ;
		merged.unk = old_flags.unk | info_s1.unk;
		wdata      = info_s1.cell_done ? '0 : merged;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = s1_fire;
			mem_waddr = idx_s1;
			mem_wdata = wdata;
		end
	end

	otd_band #(
		.DEPTH(MAX_WIDTH),
		.AW   (CNT_W)
	) u_band (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(scan_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (restart) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	// forward the write-back that lands on the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= scan_idx;
			info_s1 <= scan_info;
			byp_s1  <= s1_fire && (idx_s1 == scan_idx);
			bypd_s1 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
		end else if (s1_fire && info_s1.cell_done) begin
			cell_valid_q <= 1'b1;
		end else if (cell_ready) begin
			cell_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && info_s1.cell_done) begin
			last_cell_q <= info_s1.last;
			if (merged.occ) begin
				cell_value_q <= otd_pkg::CELL_OCCUPIED;
			end else if (merged.unk) begin
				cell_value_q <= otd_pkg::CELL_UNKNOWN;
			end else begin
				cell_value_q <= otd_pkg::CELL_FREE;
			end
		end
	end

	assign cell_valid  = cell_valid_q;
	assign cell_value  = cell_value_q;
	assign last_cell   = last_cell_q;
	assign grid_width  = otd_pkg::DIM_W'(quo_w);
	assign grid_height = otd_pkg::DIM_W'(quo_h);

`ifndef SYNTHESIS
	a_cell_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && info_s1.cell_done |=> cell_valid_q)
		else $error("finished cell not presented");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_adv && !restart |=> v_s1 && $stable(idx_s1))
		else $error("stalled stage lost its word");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart |=> v_s1)
		else $error("accepted pixel did not reach the update stage");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s1)
		else $error("pixel in flight during band clear");
`endif

endmodule
`default_nettype wire

/* src/otd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otd_div
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module otd_div #(
	parameter int NW = 14,
	parameter int DW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num_a,
	input  wire logic [NW-1:0] num_b,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo_a,
	output logic [NW-1:0]      quo_b
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] step_q;
	logic          busy_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] n_q   [2];
	logic [DW-1:0] rem_q [2];
	logic [DW:0]   trial [2];
	logic          ge    [2];
	logic [DW-1:0] rem_d [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], n_q[i][NW-1]};
			ge[i]    = trial[i] >= {1'b0, den_q};
			rem_d[i] = ge[i] ? DW'(trial[i] - {1'b0, den_q}) : DW'(trial[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			den_q  <= DW'(1);
			for (int i = 0; i < 2; i++) begin
				n_q[i]   <= NW'(1);
				rem_q[i] <= '0;
			end
		end else if (start) begin
			busy_q   <= 1'b1;
			step_q   <= CW'(NW);
			den_q    <= den;
			n_q[0]   <= num_a;
			n_q[1]   <= num_b;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
		end else if (busy_q) begin
			step_q <= step_q - CW'(1);
			if (step_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
			for (int i = 0; i < 2; i++) begin
				n_q[i]   <= {n_q[i][NW-2:0], ge[i]};
				rem_q[i] <= rem_d[i];
			end
		end
	end

	assign busy  = busy_q;
	assign quo_a = n_q[0];
	assign quo_b = n_q[1];

endmodule
`default_nettype wire

/* src/otd_band.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otd_band
// Band flag memory: one occupied and one unknown flag per cell column.
// ----------------------------------------------------------------------------
module otd_band #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire otd_pkg::band_t wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output otd_pkg::band_t     rdata
);

	otd_pkg::band_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/otd_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otd_scan
// Raster position counters and per-pixel classification.
// ----------------------------------------------------------------------------
module otd_scan #(
	parameter int MAX_WIDTH  = otd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = otd_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_SCALE  = otd_pkg::MAX_SCALE_DEF,
	parameter int CNT_W      = $clog2(MAX_WIDTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire logic                          adv,
	input  wire logic [otd_pkg::PIXEL_W-1:0]   pixel,
	input  wire logic [otd_pkg::DIM_W-1:0]     img_w,
	input  wire logic [otd_pkg::DIM_W-1:0]     img_h,
	input  wire logic [otd_pkg::SCALE_W-1:0]   scale,
	input  wire logic [otd_pkg::LEVEL_W-1:0]   occ_level,
	input  wire logic [otd_pkg::LEVEL_W-1:0]   free_limit,
	input  wire logic                          negate,
	output logic [CNT_W-1:0]                   cell_col,
	output otd_pkg::pix_info_t                 info
);

	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int BLK_W = $clog2(MAX_SCALE);

	logic [CNT_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [BLK_W-1:0] cib_q;
	logic [BLK_W-1:0] rib_q;
	logic [CNT_W-1:0] cc_q;

	logic [otd_pkg::PIXEL_W-1:0] dark;
	logic [otd_pkg::DIM_W-1:0]   w_m1;
	logic [otd_pkg::DIM_W-1:0]   h_m1;
	logic [otd_pkg::SCALE_W-1:0] s_m1;
	logic end_col, end_row, wrap_col, wrap_row;
	logic occ, fre;

	always_comb begin
		dark     = negate ? pixel : 8'd255 - pixel;
		occ      = {1'b0, dark} >= occ_level;
		fre      = {1'b0, dark} < free_limit;
		w_m1     = img_w - otd_pkg::DIM_W'(1);
		h_m1     = img_h - otd_pkg::DIM_W'(1);
		s_m1     = scale - otd_pkg::SCALE_W'(1);
		end_col  = 32'(col_q) >= 32'(w_m1);
		end_row  = 32'(row_q) >= 32'(h_m1);
		wrap_col = 32'(cib_q) >= 32'(s_m1);
		wrap_row = 32'(rib_q) >= 32'(s_m1);
		info.occ       = occ;
		info.unk       = !occ && !fre;
		info.cell_done = (end_col || wrap_col) && (end_row || wrap_row);
		info.last      = end_col && end_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
			cc_q  <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
			cc_q  <= '0;
		end else if (adv) begin
			if (end_col) begin
				col_q <= '0;
				cib_q <= '0;
				cc_q  <= '0;
				if (end_row) begin
					row_q <= '0;
					rib_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					rib_q <= wrap_row ? '0 : rib_q + BLK_W'(1);
				end
			end else begin
				col_q <= col_q + CNT_W'(1);
				if (wrap_col) begin
					cib_q <= '0;
					cc_q  <= cc_q + CNT_W'(1);
				end else begin
					cib_q <= cib_q + BLK_W'(1);
				end
			end
		end
	end

	assign cell_col = cc_q;

endmodule
`default_nettype wire
